// File: rtl/hcfp_pkg.sv
package hcfp_pkg;

  localparam logic [7:0] BYTE_START = 8'hAA;
  localparam logic [7:0] BYTE_END   = 8'hBB;
  localparam logic [7:0] LEN_LONG   = 8'd10;
  localparam logic [7:0] LEN_SHORT  = 8'd3;

  localparam logic [7:0] CHAR_S     = 8'h73;
  localparam logic [7:0] CHAR_T     = 8'h74;
  localparam logic [7:0] CHAR_P     = 8'h70;
  localparam logic [7:0] CHAR_A     = 8'h61;
  localparam logic [7:0] CHAR_B     = 8'h62;
  localparam logic [7:0] CHAR_C     = 8'h63;
  localparam logic [7:0] CHAR_D     = 8'h64;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam int MAG_W   = 27;
  localparam int PARAM_W = 28;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_PA    = 3'd2,
    CMD_PB    = 3'd3,
    CMD_PC    = 3'd4,
    CMD_PD    = 3'd5
  } cmd_code_t;

  // control from the frame parser to the number converter
  typedef struct packed {
    logic       clear;
    logic       feed;
    logic [7:0] char_in;
  } num_ctrl_t;

  typedef struct packed {
    logic             negative;
    logic [MAG_W-1:0] magnitude;
  } num_stat_t;

endpackage

// File: rtl/host_command_frame_parser_unit.sv
// Host command frame parser. Takes one received byte per request on the slave
// stream and emits a command (code in tuser, signed parameter in tdata) in the
// cycle after the end byte of a valid st/sp/pa/pb/pc/pd frame is taken. A new
// request is accepted each cycle; the only stall comes from the single result
// register, which holds a command until the master side takes it (tready is low
// only while that register is full and not being drained). A timeout request
// (tuser = 1) drops any frame in progress. Frames with a bad length or end byte,
// or an unknown type, give nothing.
module host_command_frame_parser_unit
  import hcfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [27:0] cmd_param (signed), [31:28] zero
  output logic [2:0]  m_axis_tuser    // [2:0] cmd_code
);

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_LEN   = 3'd1,
    PH_TYPE  = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4,
    PH_END   = 3'd5
  } phase_t;

  phase_t     phase;
  logic [2:0] field_byte_count;
  logic       length_prefix_zero;
  logic [3:0] data_length;
  logic [7:0] type_chars [2];

  logic       accept;
  logic       byte_req;
  logic [7:0] rx;
  num_ctrl_t  num_ctrl;
  num_stat_t  num_stat;
  logic       code_ok;
  cmd_code_t  code;
  logic [PARAM_W-1:0] param;
  logic       out_load;
  logic [3:0] data_count_inc;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign byte_req      = accept && !s_axis_tuser;
  assign rx            = s_axis_tdata;

  assign num_ctrl.clear   = byte_req && (phase == PH_TYPE) && (field_byte_count != 3'd0);
  assign num_ctrl.feed    = byte_req && (phase == PH_DATA);
  assign num_ctrl.char_in = rx;

  hcfp_num u_num (
    .clk  (clk),
    .rst  (rst),
    .ctrl (num_ctrl),
    .stat (num_stat)
  );

  always_comb begin
    code_ok = 1'b1;
    code    = CMD_START;
    if (type_chars[0] == CHAR_S && type_chars[1] == CHAR_T) begin
      code = CMD_START;
    end else if (type_chars[0] == CHAR_S && type_chars[1] == CHAR_P) begin
      code = CMD_STOP;
    end else if (type_chars[0] == CHAR_P && type_chars[1] == CHAR_A) begin
      code = CMD_PA;
    end else if (type_chars[0] == CHAR_P && type_chars[1] == CHAR_B) begin
      code = CMD_PB;
    end else if (type_chars[0] == CHAR_P && type_chars[1] == CHAR_C) begin
      code = CMD_PC;
    end else if (type_chars[0] == CHAR_P && type_chars[1] == CHAR_D) begin
      code = CMD_PD;
    end else begin
      code_ok = 1'b0;
    end
  end

  assign param = num_stat.negative ? (PARAM_W'(0) - {1'b0, num_stat.magnitude})
                                   : {1'b0, num_stat.magnitude};

  assign out_load       = byte_req && (phase == PH_END) && (rx == BYTE_END) && code_ok;
  assign data_count_inc = {1'b0, field_byte_count} + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HUNT;
      field_byte_count   <= '0;
      length_prefix_zero <= 1'b1;
      data_length        <= '0;
      type_chars[0]      <= '0;
      type_chars[1]      <= '0;
      m_axis_tvalid      <= 1'b0;
      m_axis_tdata       <= '0;
      m_axis_tuser       <= '0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tuser  <= code;
        m_axis_tdata  <= {{(32-PARAM_W){1'b0}}, param};
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (accept && s_axis_tuser) begin
        phase            <= PH_HUNT;
        field_byte_count <= '0;
      end else if (byte_req) begin
        case (phase)
          PH_LEN: begin
            if (field_byte_count < 3'd3) begin
              if (rx != 8'd0) begin
                length_prefix_zero <= 1'b0;
              end
              field_byte_count <= field_byte_count + 3'd1;
            end else if (length_prefix_zero && (rx == LEN_LONG || rx == LEN_SHORT)) begin
              data_length      <= 4'(rx - 8'd2);
              phase            <= PH_TYPE;
              field_byte_count <= '0;
            end else begin
              phase            <= PH_HUNT;
              field_byte_count <= '0;
            end
          end
          PH_TYPE: begin
            type_chars[field_byte_count[0]] <= rx;
            if (field_byte_count != 3'd0) begin
              phase            <= PH_DATA;
              field_byte_count <= '0;
            end else begin
              field_byte_count <= field_byte_count + 3'd1;
            end
          end
          PH_DATA: begin
            if (data_count_inc >= data_length) begin
              phase            <= PH_CHECK;
              field_byte_count <= '0;
            end else begin
              field_byte_count <= data_count_inc[2:0];
            end
          end
          PH_CHECK: begin
            if (field_byte_count != 3'd0) begin
              phase            <= PH_END;
              field_byte_count <= '0;
            end else begin
              field_byte_count <= field_byte_count + 3'd1;
            end
          end
          PH_END: begin
            phase            <= PH_HUNT;
            field_byte_count <= '0;
          end
          default: begin
            // hunt, and any phase code with no meaning
            if (rx == BYTE_START) begin
              phase              <= PH_LEN;
              field_byte_count   <= '0;
              length_prefix_zero <= 1'b1;
              data_length        <= '0;
            end else begin
              phase            <= PH_HUNT;
              field_byte_count <= '0;
            end
          end
        endcase
      end
    end
  end

  // a command is only produced from the end-byte phase
  a_out_from_end: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (phase == PH_END))
    else $error("command loaded outside end phase");

  // a loaded command is offered in the next cycle
  a_out_offered: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_axis_tvalid && m_axis_tdata[31:PARAM_W] == '0))
    else $error("loaded command not offered");

  // data phase only entered with a checked length
  a_data_len: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (data_length == 4'd8 || data_length == 4'd1))
    else $error("data phase with bad length");

  // data count stays below the data length
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> ({1'b0, field_byte_count} < data_length))
    else $error("data byte count overrun");

  // new request never taken while a result is stuck
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !out_load)
    else $error("result overwritten while stalled");

endmodule

// File: rtl/hcfp_num.sv
module hcfp_num
  import hcfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  num_ctrl_t ctrl,
  output num_stat_t stat
);

  typedef enum logic [1:0] {
    NUM_SKIP   = 2'd0,
    NUM_DIGITS = 2'd1,
    NUM_DONE   = 2'd2
  } num_phase_t;

  num_phase_t       phase;
  logic             negative;
  logic [MAG_W-1:0] magnitude;

  logic             is_digit;
  logic             is_blank;
  logic [3:0]       digit_val;
  logic [MAG_W-1:0] mag_x10;
  logic [MAG_W-1:0] mag_acc;

  assign is_digit  = (ctrl.char_in >= CHAR_ZERO) && (ctrl.char_in <= CHAR_NINE);
  assign is_blank  = (ctrl.char_in == CHAR_SPACE) ||
                     ((ctrl.char_in >= CHAR_TAB) && (ctrl.char_in <= CHAR_CR));
  assign digit_val = 4'(ctrl.char_in - CHAR_ZERO);
  // x10 as x8 + x2, wraps at the accumulator width
  assign mag_x10   = {magnitude[MAG_W-4:0], 3'b000} + {magnitude[MAG_W-2:0], 1'b0};
  assign mag_acc   = mag_x10 + {{(MAG_W-4){1'b0}}, digit_val};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= NUM_SKIP;
      negative  <= 1'b0;
      magnitude <= '0;
    end else if (ctrl.clear) begin
      phase     <= NUM_SKIP;
      negative  <= 1'b0;
      magnitude <= '0;
    end else if (ctrl.feed) begin
      case (phase)
        NUM_SKIP: begin
          if (!is_blank) begin
            if (ctrl.char_in == CHAR_PLUS) begin
              phase <= NUM_DIGITS;
            end else if (ctrl.char_in == CHAR_MINUS) begin
              negative <= 1'b1;
              phase    <= NUM_DIGITS;
            end else if (is_digit) begin
              magnitude <= {{(MAG_W-4){1'b0}}, digit_val};
              phase     <= NUM_DIGITS;
            end else begin
              phase <= NUM_DONE;
            end
          end
        end
        NUM_DIGITS: begin
          if (is_digit) begin
            magnitude <= mag_acc;
          end else begin
            phase <= NUM_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.negative  = negative;
  assign stat.magnitude = magnitude;

endmodule

// File: sim/testbench.sv
module testbench;
  import hcfp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 780;

  typedef enum logic [2:0] {
    PH_HUNT, PH_LEN, PH_TYPE, PH_DATA, PH_CHECK, PH_END
  } parse_phase_t;

  typedef enum logic [1:0] {
    NUM_SKIP, NUM_DIGITS, NUM_DONE
  } number_phase_t;

  typedef struct {
    cmd_code_t          code;
    logic [PARAM_W-1:0] param;
  } command_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic        s_axis_tuser = 1'b0;    // [0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [27:0] cmd_param (signed), [31:28] zero
  logic [2:0]  m_axis_tuser;           // [2:0] cmd_code

  host_command_frame_parser_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // parser mirror
  parse_phase_t     frm_phase;
  logic [2:0]       frm_count;
  logic             len_zero;
  logic [3:0]       body_len;
  logic [7:0]       type_ch [2];
  number_phase_t    num_phase;
  logic             num_neg;
  logic [MAG_W-1:0] num_mag;

  command_t cmd_expected_q [$];

  int items_sent;
  int burst_left;
  int mismatches  = 0;
  int idle_cycles = 0;
  int ready_mode  = 0;
  int ready_run   = 0;
  int mode_timer  = 0;
  logic ready_level = 1'b1;

  task clear_mirror();
    frm_phase = PH_HUNT;
    frm_count = '0;
    len_zero  = 1'b1;
    body_len  = '0;
    type_ch[0] = '0;
    type_ch[1] = '0;
    num_phase = NUM_SKIP;
    num_neg   = 1'b0;
    num_mag   = '0;
  endtask

  // atoll-style conversion, one char at a time
  task feed_number(input logic [7:0] c);
    logic digit;
    digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    case (num_phase)
      NUM_SKIP: begin
        if (!(c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))) begin
          if (c == CHAR_PLUS) begin
            num_phase = NUM_DIGITS;
          end else if (c == CHAR_MINUS) begin
            num_neg   = 1'b1;
            num_phase = NUM_DIGITS;
          end else if (digit) begin
            num_mag   = MAG_W'(c - CHAR_ZERO);
            num_phase = NUM_DIGITS;
          end else begin
            num_phase = NUM_DONE;
          end
        end
      end
      NUM_DIGITS: begin
        if (digit) begin
          num_mag = MAG_W'(num_mag * 10) + MAG_W'(c - CHAR_ZERO);
        end else begin
          num_phase = NUM_DONE;
        end
      end
      default: ;
    endcase
  endtask

  task predict_request(input logic req, input logic [7:0] b);
    command_t  cmd;
    logic      hit;
    cmd_code_t code;
    if (req) begin
      frm_phase = PH_HUNT;
      frm_count = '0;
    end else begin
      case (frm_phase)
        PH_LEN: begin
          if (frm_count < 3) begin
            if (b != 8'h00) len_zero = 1'b0;
            frm_count = frm_count + 3'd1;
          end else if (len_zero && (b == LEN_LONG || b == LEN_SHORT)) begin
            body_len  = 4'(b - 8'd2);
            frm_phase = PH_TYPE;
            frm_count = '0;
          end else begin
            frm_phase = PH_HUNT;
            frm_count = '0;
          end
        end
        PH_TYPE: begin
          type_ch[frm_count[0]] = b;
          if (frm_count >= 1) begin
            frm_phase = PH_DATA;
            frm_count = '0;
            num_phase = NUM_SKIP;
            num_neg   = 1'b0;
            num_mag   = '0;
          end else begin
            frm_count = frm_count + 3'd1;
          end
        end
        PH_DATA: begin
          feed_number(b);
          if (int'(frm_count) + 1 >= int'(body_len)) begin
            frm_phase = PH_CHECK;
            frm_count = '0;
          end else begin
            frm_count = frm_count + 3'd1;
          end
        end
        PH_CHECK: begin
          if (frm_count >= 1) begin
            frm_phase = PH_END;
            frm_count = '0;
          end else begin
            frm_count = frm_count + 3'd1;
          end
        end
        PH_END: begin
          hit  = 1'b1;
          code = CMD_START;
          case ({type_ch[0], type_ch[1]})
            {CHAR_S, CHAR_T}: code = CMD_START;
            {CHAR_S, CHAR_P}: code = CMD_STOP;
            {CHAR_P, CHAR_A}: code = CMD_PA;
            {CHAR_P, CHAR_B}: code = CMD_PB;
            {CHAR_P, CHAR_C}: code = CMD_PC;
            {CHAR_P, CHAR_D}: code = CMD_PD;
            default: hit = 1'b0;
          endcase
          frm_phase = PH_HUNT;
          frm_count = '0;
          if (b == BYTE_END && hit) begin
            cmd.code  = code;
            cmd.param = {1'b0, num_mag};
            if (num_neg) cmd.param = -cmd.param;
            cmd_expected_q.push_back(cmd);
          end
        end
        default: begin
          if (b == BYTE_START) begin
            frm_phase = PH_LEN;
            frm_count = '0;
            len_zero  = 1'b1;
            body_len  = '0;
          end else begin
            frm_phase = PH_HUNT;
            frm_count = '0;
          end
        end
      endcase
    end
  endtask

  // one request on the slave side, bursts separated by random gaps
  task automatic send_item(input logic req, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'($urandom);
        s_axis_tuser  <= 1'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_request(req, b);
    items_sent++;
    burst_left--;
  endtask

  task pause_until_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (cmd_expected_q.size() != 0) @(posedge clk);
  endtask

  // abort_at < 0: no timeout inside the frame
  task automatic send_frame(input logic [15:0] kind, input logic [23:0] len_hi,
                            input logic [7:0] len_lo, input logic [63:0] body,
                            input int nbody, input logic [7:0] tail, input int abort_at);
    logic [7:0] seq [0:17];
    int n;
    int i;
    seq[0] = BYTE_START;
    seq[1] = len_hi[23:16];
    seq[2] = len_hi[15:8];
    seq[3] = len_hi[7:0];
    seq[4] = len_lo;
    seq[5] = kind[15:8];
    seq[6] = kind[7:0];
    n = 7;
    for (i = 0; i < nbody; i++) begin
      seq[n] = body[63 - 8 * i -: 8];
      n++;
    end
    seq[n]     = 8'($urandom);
    seq[n + 1] = 8'($urandom);
    seq[n + 2] = tail;
    n = n + 3;
    for (i = 0; i < n; i++) begin
      if (i == abort_at) begin
        send_item(1'b1, 8'($urandom));
        break;
      end
      send_item(1'b0, seq[i]);
    end
  endtask

  function automatic logic [7:0] blank_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CHAR_SPACE : CHAR_TAB + 8'(k);
  endfunction

  function automatic logic [63:0] make_body();
    logic [63:0] v;
    logic [7:0]  c;
    int i;
    int blanks;
    int style;
    int sel;
    style  = $urandom_range(0, 3);
    blanks = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    for (i = 0; i < 8; i++) begin
      sel = $urandom_range(0, 99);
      if (style == 3) begin
        if (sel < 40)      c = CHAR_ZERO + 8'($urandom_range(0, 9));
        else if (sel < 52) c = blank_char();
        else if (sel < 60) c = CHAR_PLUS;
        else if (sel < 68) c = CHAR_MINUS;
        else if (sel < 74) c = 8'h00;
        else               c = 8'($urandom);
      end else if (i < blanks) begin
        c = blank_char();
      end else if (i == blanks && sel < 50) begin
        c = (sel < 25) ? CHAR_MINUS : CHAR_PLUS;
      end else if (sel < 95) begin
        c = CHAR_ZERO + 8'($urandom_range(0, 9));
      end else begin
        c = 8'($urandom);
      end
      v[63 - 8 * i -: 8] = c;
    end
    return v;
  endfunction

  function automatic logic [15:0] pick_kind();
    int r;
    r = $urandom_range(0, 19);
    case (r % 6)
      0: pick_kind = {CHAR_S, CHAR_T};
      1: pick_kind = {CHAR_S, CHAR_P};
      2: pick_kind = {CHAR_P, CHAR_A};
      3: pick_kind = {CHAR_P, CHAR_B};
      4: pick_kind = {CHAR_P, CHAR_C};
      default: pick_kind = {CHAR_P, CHAR_D};
    endcase
    if (r == 17) pick_kind = {CHAR_S, 8'($urandom)};
    if (r == 18) pick_kind = {CHAR_P, 8'($urandom)};
    if (r == 19) pick_kind = 16'($urandom);
  endfunction

  task automatic random_frame();
    logic [7:0]  lo;
    logic [23:0] hi;
    logic [7:0]  tail;
    int shape;
    int ab;
    lo    = ($urandom_range(0, 3) == 0) ? LEN_SHORT : LEN_LONG;
    hi    = '0;
    tail  = BYTE_END;
    ab    = -1;
    shape = $urandom_range(0, 99);
    if (shape < 4)       hi = 24'(1) << $urandom_range(0, 23);
    else if (shape < 8)  lo = 8'($urandom);
    else if (shape < 14) tail = 8'($urandom);
    else if (shape < 20) ab = $urandom_range(0, 15);
    send_frame(pick_kind(), hi, lo, make_body(), (lo == LEN_SHORT) ? 1 : 8, tail, ab);
  endtask

  task automatic send_noise(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      send_item(($urandom_range(0, 9) == 0), 8'($urandom));
    end
  endtask

  task test_commands();
    send_frame({CHAR_S, CHAR_T}, 24'h0, LEN_LONG, "99999999", 8, BYTE_END, -1);
    send_frame({CHAR_S, CHAR_P}, 24'h0, LEN_LONG, "-9999999", 8, BYTE_END, -1);
    send_frame({CHAR_P, CHAR_A}, 24'h0, LEN_SHORT, {"7", 56'h0}, 1, BYTE_END, -1);
    send_frame({CHAR_P, CHAR_B}, 24'h0, LEN_LONG, " \t\r+0042", 8, BYTE_END, -1);
    send_frame({CHAR_P, CHAR_C}, 24'h0, LEN_LONG, "12ab3456", 8, BYTE_END, -1);
    send_frame({CHAR_P, CHAR_D}, 24'h0, LEN_LONG, "  -  5  ", 8, BYTE_END, -1);
  endtask

  task test_number_edges();
    // zero byte stops the digits
    send_frame({CHAR_S, CHAR_T}, 24'h0, LEN_LONG, {"12", 8'h00, " 34  "}, 8, BYTE_END, -1);
    // no digits at all
    send_frame({CHAR_S, CHAR_P}, 24'h0, LEN_SHORT, {"x", 56'h0}, 1, BYTE_END, -1);
    send_frame({CHAR_P, CHAR_A}, 24'h0, LEN_LONG, "00000000", 8, BYTE_END, -1);
  endtask

  task test_bad_frames();
    send_item(1'b1, 8'hFF);                  // timeout while hunting
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_frame({8'h78, 8'h79}, 24'h0, LEN_LONG, "00001234", 8, BYTE_END, -1);
    send_frame({CHAR_S, CHAR_T}, 24'h000100, LEN_LONG, "11111111", 8, BYTE_END, -1);
    send_frame({CHAR_S, CHAR_T}, 24'h0, 8'd11, "22222222", 8, BYTE_END, -1);
    send_frame({CHAR_P, CHAR_B}, 24'h0, LEN_LONG, "33333333", 8, 8'hBA, -1);
    send_frame({CHAR_P, CHAR_C}, 24'h0, LEN_LONG, "44444444", 8, BYTE_END, 9);
    send_frame({CHAR_P, CHAR_D}, 24'h0, LEN_SHORT, {"5", 56'h0}, 1, BYTE_END, -1);
  endtask

  task test_drain_pause();
    send_frame({CHAR_S, CHAR_T}, 24'h0, LEN_SHORT, {"9", 56'h0}, 1, BYTE_END, -1);
    pause_until_drained();
    send_frame({CHAR_S, CHAR_P}, 24'h0, LEN_SHORT, {"1", 56'h0}, 1, BYTE_END, -1);
  endtask

  task automatic test_random_traffic();
    int target;
    int frames;
    int pick;
    target = items_sent + RANDOM_ITEMS;
    frames = 0;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        random_frame();
        frames++;
        if (frames % 40 == 0) pause_until_drained();
      end else if (pick < 85) begin
        send_noise($urandom_range(1, 6));
      end else if (pick < 92) begin
        send_item(1'b1, 8'($urandom));
      end else begin
        send_item(1'b0, BYTE_START);
        random_frame();
      end
    end
  endtask

  // receiver: ready pattern changes mode on a free-running timer
  always @(negedge clk) begin
    mode_timer++;
    if (mode_timer % 256 == 0) ready_mode = $urandom_range(0, 2);
    if (ready_run == 0) begin
      case (ready_mode)
        0: begin
          ready_level = 1'b1;
          ready_run   = $urandom_range(1, 30);
        end
        1: begin
          ready_level = 1'($urandom);
          ready_run   = $urandom_range(0, 6);
        end
        default: begin
          ready_level = ($urandom_range(0, 3) == 0);
          ready_run   = ready_level ? 1 : $urandom_range(1, 12);
        end
      endcase
    end else begin
      ready_run--;
    end
    m_axis_tready <= ready_level;
  end

  // result checker
  always @(posedge clk) begin
    command_t cmd;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (cmd_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected command: code %0d tdata %h", m_axis_tuser, m_axis_tdata);
      end else begin
        cmd = cmd_expected_q.pop_front();
        if (m_axis_tuser != cmd.code || m_axis_tdata != {4'h0, cmd.param}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("command mismatch: expected code %0d param %0d, got code %0d tdata %h",
                     cmd.code, $signed(cmd.param), m_axis_tuser, m_axis_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** host_command_frame_parser_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    items_sent  = 0;
    burst_left  = 0;
    clear_mirror();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_commands();
    test_number_edges();
    test_bad_frames();
    test_drain_pause();
    test_random_traffic();

    pause_until_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && cmd_expected_q.size() == 0) begin
      $display("** host_command_frame_parser_unit: PASSED **");
    end else begin
      $display("** host_command_frame_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule
